FILE: rtl/rrp_pkg.sv
// rrp_pkg: shared types and constants for the rectangle raster painter
// holds operation, status, register index codes, fsm states and ctrl/datapath structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rrp_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_ZERO_RECT  = 2'd1,
    STS_OUT_CANVAS = 2'd2,
    STS_UNUSED     = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CANVAS_WIDTH  = 2'd0,
    REG_CANVAS_HEIGHT = 2'd1,
    REG_BACKGROUND    = 2'd2,
    REG_NONE          = 2'd3
  } reg_index_t;

  // register reset values
  localparam logic [8:0] CANVAS_WIDTH_RESET  = 9'd256;
  localparam logic [8:0] CANVAS_HEIGHT_RESET = 9'd256;
  localparam logic [7:0] BACKGROUND_RESET    = 8'd32;

  // controller states
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SETUP,
    CS_SCAN,
    CS_RD_ADDR,
    CS_RD_MEM,
    CS_DONE
  } ctrl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_item;    // capture the accepted input word
    logic setup;        // compute bounds, rewind scan counters
    logic scan;         // visit one cell, advance counters
    logic rd_addr;      // form the read address
    logic load_result;  // capture the result word
  } rrp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic zero_rect;
    logic empty_canvas;
    logic out_of_canvas;
    logic last_cell;
  } rrp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/rrp_ctrl.sv
// rrp_ctrl: sequencing state machine for clear, draw and read items
// depends on rrp_pkg; drives rrp_datapath through rrp_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module rrp_ctrl (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire                       out_ready,
  output rrp_pkg::rrp_cmd_t         cmd,
  input  wire rrp_pkg::rrp_stat_t   stat
);

  rrp_pkg::ctrl_state_t state, state_next;
  logic                 out_valid_next;

  // state register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rrp_pkg::CS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next      = state;
    cmd             = '0;
    in_ready        = 1'b0;
    out_valid_next  = out_valid && !out_ready;
    unique case (state)
      rrp_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = rrp_pkg::CS_SETUP;
        end
      end
      rrp_pkg::CS_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = rrp_pkg::CS_DONE;
        unique case (stat.op)
          rrp_pkg::OP_CLEAR: begin
            if (!stat.empty_canvas) state_next = rrp_pkg::CS_SCAN;
          end
          rrp_pkg::OP_DRAW: begin
            if (!stat.empty_canvas && !stat.zero_rect) state_next = rrp_pkg::CS_SCAN;
          end
          rrp_pkg::OP_READ: begin
            if (!stat.out_of_canvas) state_next = rrp_pkg::CS_RD_ADDR;
          end
          default: begin
            state_next = rrp_pkg::CS_DONE;
          end
        endcase
      end
      rrp_pkg::CS_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.last_cell) state_next = rrp_pkg::CS_DONE;
      end
      rrp_pkg::CS_RD_ADDR: begin
        cmd.rd_addr = 1'b1;
        state_next  = rrp_pkg::CS_RD_MEM;
      end
      rrp_pkg::CS_RD_MEM: begin
        state_next = rrp_pkg::CS_DONE;
      end
      rrp_pkg::CS_DONE: begin
        // hand over once the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_result = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = rrp_pkg::CS_IDLE;
        end
      end
      default: begin
        state_next = rrp_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/rrp_datapath.sv
// rrp_datapath: canvas memory, configuration registers, scan counters and edge tests
// depends on rrp_pkg; controlled by rrp_ctrl
`timescale 1ns / 1ps
`default_nettype none

module rrp_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire rrp_pkg::rrp_cmd_t    cmd,
  output rrp_pkg::rrp_stat_t        stat,
  // configuration write
  input  wire                  cfg_write,
  input  wire  [1:0]           cfg_index,
  input  wire  [8:0]           cfg_data,
  // input item fields
  input  wire  [1:0]           operation,
  input  wire  [19:0]          left_edge,
  input  wire  [19:0]          top_edge,
  input  wire  [18:0]          rect_width,
  input  wire  [18:0]          rect_height,
  input  wire                  filled,
  input  wire  [7:0]           paint_char,
  input  wire  [7:0]           cell_col,
  input  wire  [7:0]           cell_row,
  // result fields
  output logic [7:0]           cell_char,
  output logic [1:0]           status
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = 9 + FRAC_BITS + 1;
  localparam int GW    = ((XW > 22) ? XW : 22) + 2;
  localparam int MW    = $clog2(MAX_WIDTH + 1);
  localparam int PW    = 8 + MW;
  localparam logic signed [GW-1:0] ONE = {{(GW-1){1'b0}}, 1'b1} << FRAC_BITS;

  // configuration registers
  logic [8:0] canvas_width;
  logic [8:0] canvas_height;
  logic [7:0] background_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= rrp_pkg::CANVAS_WIDTH_RESET;
      canvas_height   <= rrp_pkg::CANVAS_HEIGHT_RESET;
      background_char <= rrp_pkg::BACKGROUND_RESET;
    end else if (cfg_write) begin
      unique case (rrp_pkg::reg_index_t'(cfg_index))
        rrp_pkg::REG_CANVAS_WIDTH:  canvas_width    <= cfg_data;
        rrp_pkg::REG_CANVAS_HEIGHT: canvas_height   <= cfg_data;
        rrp_pkg::REG_BACKGROUND:    background_char <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // dimensions in use, clamped to the memory size
  logic [8:0] used_w;
  logic [8:0] used_h;

  always_comb begin
    used_w = (32'(canvas_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : canvas_width;
    used_h = (32'(canvas_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : canvas_height;
  end

  // captured item word
  rrp_pkg::op_t op;
  logic [19:0]  left_raw;
  logic [19:0]  top_raw;
  logic [18:0]  rw_raw;
  logic [18:0]  rh_raw;
  logic         fill;
  logic [7:0]   pchar;
  logic [7:0]   rcol;
  logic [7:0]   rrow;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op       <= rrp_pkg::op_t'(operation);
      left_raw <= left_edge;
      top_raw  <= top_edge;
      rw_raw   <= rect_width;
      rh_raw   <= rect_height;
      fill     <= filled;
      pchar    <= paint_char;
      rcol     <= cell_col;
      rrow     <= cell_row;
    end
  end

  // rectangle bounds, formed once per draw
  logic signed [GW-1:0] left_sx, top_sx, rw_ext, rh_ext;
  logic signed [GW-1:0] left_q, top_q, right_q, bottom_q;

  always_comb begin
    left_sx = {{(GW-20){left_raw[19]}}, left_raw};
    top_sx  = {{(GW-20){top_raw[19]}}, top_raw};
    rw_ext  = {{(GW-19){1'b0}}, rw_raw};
    rh_ext  = {{(GW-19){1'b0}}, rh_raw};
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      left_q   <= left_sx;
      top_q    <= top_sx;
      right_q  <= left_sx + rw_ext;
      bottom_q <= top_sx + rh_ext;
    end
  end

  // scan counters, row base tracks row * MAX_WIDTH
  logic [8:0]    col;
  logic [8:0]    row;
  logic [AW-1:0] row_base;
  logic          last_col;
  logic          last_row;

  assign last_col = (col == used_w - 9'd1);
  assign last_row = (row == used_h - 9'd1);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      col      <= '0;
      row      <= '0;
      row_base <= '0;
    end else if (cmd.scan) begin
      if (last_col) begin
        col      <= '0;
        row      <= row + 9'd1;
        row_base <= row_base + AW'(MAX_WIDTH);
      end else begin
        col <= col + 9'd1;
      end
    end
  end

  // per-cell edge tests
  logic signed [GW-1:0] x, y;
  logic signed [GW-1:0] dx_l, dx_r, dy_t, dy_b;
  logic                 in_x, in_y, near_x, near_y, paint;

  always_comb begin
    x      = {{(GW-9){1'b0}}, col} <<< FRAC_BITS;
    y      = {{(GW-9){1'b0}}, row} <<< FRAC_BITS;
    dx_l   = x - left_q;
    dx_r   = right_q - x;
    dy_t   = y - top_q;
    dy_b   = bottom_q - y;
    in_x   = (x >= left_q) && (x <= right_q);
    in_y   = (y >= top_q) && (y <= bottom_q);
    near_x = (dx_l < ONE) || (dx_r < ONE);
    near_y = (dy_t < ONE) || (dy_b < ONE);
    paint  = in_x && in_y && (fill || near_x || near_y);
  end

  // canvas memory write port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  always_comb begin
    wr_addr = row_base + AW'(col);
    wr_en   = cmd.scan && ((op == rrp_pkg::OP_CLEAR) || paint);
    wr_data = (op == rrp_pkg::OP_CLEAR) ? background_char : pchar;
  end

  // read address: row * MAX_WIDTH + col
  logic [PW-1:0] rd_sum;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  assign rd_sum = ({{MW{1'b0}}, rrow} * PW'(MAX_WIDTH)) + {{MW{1'b0}}, rcol};

  always_ff @(posedge clk) begin
    if (cmd.rd_addr) begin
      rd_addr <= AW'(rd_sum);
    end
  end

  // canvas memory
  logic [7:0] canvas_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      canvas_mem[wr_addr] <= wr_data;
    end
    rd_data <= canvas_mem[rd_addr];
  end

  // status toward the controller
  always_comb begin
    stat.op            = op;
    stat.zero_rect     = (rw_raw == '0) || (rh_raw == '0);
    stat.empty_canvas  = (used_w == '0) || (used_h == '0);
    stat.out_of_canvas = ({1'b0, rcol} >= used_w) || ({1'b0, rrow} >= used_h);
    stat.last_cell     = last_col && last_row;
  end

  // result word for the item in work
  logic [7:0] cell_char_next;
  logic [1:0] status_next;

  always_comb begin
    cell_char_next = '0;
    status_next    = rrp_pkg::STS_OK;
    case (op)
      rrp_pkg::OP_DRAW: begin
        if (stat.zero_rect) status_next = rrp_pkg::STS_ZERO_RECT;
      end
      rrp_pkg::OP_READ: begin
        if (stat.out_of_canvas) status_next = rrp_pkg::STS_OUT_CANVAS;
        else cell_char_next = rd_data;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      cell_char <= cell_char_next;
      status    <= status_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rectangle_raster_painter_core.sv
// rectangle_raster_painter_core: clear/draw/read items; a clear or draw visits all
// used_w*used_h cells (one canvas cell per cycle through the memory write port), and a
// read adds address and memory read states; one item is in work at a time.
// the next item is accepted while the result still waits in the output register.
// rst clears the controller, output valid and the configuration registers;
// canvas contents are undefined until a clear, and no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module rectangle_raster_painter_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  wire          clk,
  input  wire          rst,
  // input item stream
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [103:0] s_tdata,   // left_edge, top_edge, rect_width, rect_height,
                                  // filled, paint_char, cell_col, cell_row, pad
  input  wire  [1:0]   s_tuser,   // operation
  // result stream
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [15:0]  m_tdata,   // cell_char, status, pad
  // configuration write
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [1:0]   cfg_index,
  input  wire  [8:0]   cfg_data
);

  rrp_pkg::rrp_cmd_t  cmd;
  rrp_pkg::rrp_stat_t stat;
  logic [7:0]         cell_char;
  logic [1:0]         status;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {6'd0, status, cell_char};

  // sequencer
  rrp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // canvas and geometry
  rrp_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .operation   (s_tuser),
    .left_edge   (s_tdata[19:0]),
    .top_edge    (s_tdata[39:20]),
    .rect_width  (s_tdata[58:40]),
    .rect_height (s_tdata[77:59]),
    .filled      (s_tdata[78]),
    .paint_char  (s_tdata[86:79]),
    .cell_col    (s_tdata[94:87]),
    .cell_row    (s_tdata[102:95]),
    .cell_char   (cell_char),
    .status      (status)
  );

  // one item in work at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted again right after an accept");

  // scan stops after the last cell
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    cmd.scan && stat.last_cell |=> !cmd.scan)
    else $error("scan continued past the last cell");

  // no scan over an empty canvas
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !stat.empty_canvas)
    else $error("scan running on an empty canvas");

  // a captured result is presented
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |=> m_tvalid)
    else $error("result loaded but not presented");

endmodule

`default_nettype wire
